// ----- hdl/sbpm_pkg.sv -----
// sbpm_pkg: shared constants and types of the spectrum bar peak meter
// field widths, register indexes, level thresholds and parameter defaults
// no dependencies
`timescale 1ns / 1ps

package sbpm_pkg;

    localparam int BIN_W = 7;
    localparam int MAG_W = 32;
    localparam int SUM_W = 34;
    localparam int BAND_OUT_W = 4;
    localparam int HEIGHT_W = 4;
    localparam int PEAK_W = 3;
    localparam int TICK_W = 16;
    localparam int SKIP_W = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_NUM_BANDS = 16;
    localparam int DEF_BIN_STRIDE = 8;
    localparam int DEF_USED_BINS = 4;
    localparam int DEF_BAR_ROWS = 8;

    localparam logic [TICK_W-1:0] DECAY_PERIOD_RST = 16'd150;
    localparam logic [SKIP_W-1:0] LOW_SKIP_RST = 3'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_BINS_SKIPPED = 1'd1;

    localparam logic KIND_BAR = 1'b0;
    localparam logic KIND_DECAY = 1'b1;
    localparam logic CMD_BIN = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam int THR_CNT = 8;
    localparam logic [SUM_W-1:0] LEVEL_THR [THR_CNT] = '{
        34'd21481763, 34'd27833635, 34'd36063670, 34'd46727218,
        34'd60543834, 34'd78445840, 34'd101641232, 34'd131695192
    };

    typedef logic signed [HEIGHT_W-1:0] t_height;

endpackage

// ----- hdl/sbpm_if.sv -----
// sbpm_if: valid/ready channels of the spectrum bar peak meter
// bin/tick input, result output and register write channels
// depends on sbpm_pkg
`timescale 1ns / 1ps

interface sbpm_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [sbpm_pkg::BIN_W-1:0]    bin_index;
    logic [sbpm_pkg::MAG_W-1:0]    magnitude;

    modport source (output valid, command, bin_index, magnitude, input ready);
    modport sink (input valid, command, bin_index, magnitude, output ready);
endinterface

interface sbpm_out_if;
    logic                              valid;
    logic                              ready;
    logic                              kind;
    logic [sbpm_pkg::BAND_OUT_W-1:0]   band;
    sbpm_pkg::t_height                 bar_height;
    logic [sbpm_pkg::PEAK_W-1:0]       peak;
    logic                              last;

    modport source (output valid, kind, band, bar_height, peak, last, input ready);
    modport sink (input valid, kind, band, bar_height, peak, last, output ready);
endinterface

interface sbpm_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sbpm_pkg::CFG_IDX_W-1:0]    index;
    logic [sbpm_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/sbpm_ram.sv -----
// sbpm_ram: generic single-port-write, single-port-read ram
// registered read data
// no dependencies
`timescale 1ns / 1ps

module sbpm_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/sbpm_grade.sv -----
// sbpm_grade: grades a band sum into a bar height
// compares against the level thresholds, -1 when none is met
// depends on sbpm_pkg
`timescale 1ns / 1ps

module sbpm_grade #(
    parameter int BAR_ROWS = sbpm_pkg::DEF_BAR_ROWS
) (
    input  logic [sbpm_pkg::SUM_W-1:0] i_sum,
    output sbpm_pkg::t_height          o_height
);

    localparam int ROWS_USED = (BAR_ROWS < sbpm_pkg::THR_CNT) ? BAR_ROWS : sbpm_pkg::THR_CNT;

    always_comb begin
        o_height = -4'sd1;
        for (int k = 0; k < ROWS_USED; k++) begin
            if (i_sum >= sbpm_pkg::LEVEL_THR[k]) begin
                o_height = sbpm_pkg::HEIGHT_W'(k);
            end
        end
    end

endmodule

// ----- hdl/spectrum_bar_peak_meter_unit.sv -----
// Spectrum bar graph meter with peak hold. Bin beats are taken while idle; the
// last used bin of a band is followed by a grading step (grading and peak
// write back, the peak memory read is issued as the beat is taken) before
// the next beat is taken. A tick that triggers a decay produces NUM_BANDS
// reports, each from a peak read state and then a write back state. A result
// held by a stalled receiver stretches either case. Peaks live in a NUM_BANDS
// entry memory with one valid flip-flop per entry, so reset is immediate.
// Depends on sbpm_pkg, sbpm_if, sbpm_ram and sbpm_grade.
`timescale 1ns / 1ps

module spectrum_bar_peak_meter_unit #(
    parameter int NUM_BANDS = sbpm_pkg::DEF_NUM_BANDS,
    parameter int BIN_STRIDE = sbpm_pkg::DEF_BIN_STRIDE,
    parameter int USED_BINS = sbpm_pkg::DEF_USED_BINS,
    parameter int BAR_ROWS = sbpm_pkg::DEF_BAR_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbpm_in_if.sink    i_bin_ch,
    sbpm_cfg_if.sink   i_cfg_ch,
    sbpm_out_if.source o_res_ch
);

    localparam int AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int OFF_W = $clog2(BIN_STRIDE);
    localparam int OFX_W = OFF_W + sbpm_pkg::SKIP_W;
    localparam int BIN_N = 2 ** sbpm_pkg::BIN_W;
    localparam int PW = sbpm_pkg::PEAK_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GRADE = 2'd1;
    localparam logic [1:0] ST_DEC_RD = 2'd2;
    localparam logic [1:0] ST_DEC_WR = 2'd3;

    logic [1:0]                       r_state, n_state;
    logic [sbpm_pkg::SUM_W-1:0]       r_band_sum, n_band_sum;
    logic [sbpm_pkg::TICK_W-1:0]      r_ticks, n_ticks;
    logic [sbpm_pkg::TICK_W-1:0]      r_decay_period;
    logic [sbpm_pkg::SKIP_W-1:0]      r_skip;
    logic [AW-1:0]                    r_band, n_band;
    logic [NUM_BANDS-1:0]             r_vld;
    logic                             r_rd_vld;

    logic                             r_out_vld;
    logic                             r_out_kind;
    logic [AW-1:0]                    r_out_band;
    sbpm_pkg::t_height                r_out_height;
    logic [PW-1:0]                    r_out_peak;
    logic                             r_out_last;

    logic [sbpm_pkg::BIN_W-1:0]       w_band_tab [BIN_N];
    logic [OFF_W-1:0]                 w_off_tab [BIN_N];
    logic [sbpm_pkg::BIN_W-1:0]       w_band;
    logic [OFF_W-1:0]                 w_off;
    logic [OFX_W-1:0]                 w_offx;
    logic                             w_bin_ok;
    logic                             w_skip;
    logic                             w_close;
    logic [sbpm_pkg::SUM_W-1:0]       w_sum_base;
    logic [sbpm_pkg::SUM_W-1:0]       w_sum_add;
    logic [sbpm_pkg::TICK_W-1:0]      w_tick_inc;
    logic                             w_accept;
    logic                             w_out_free;
    logic                             w_load;
    logic                             w_we;
    logic [PW-1:0]                    w_wdata;
    logic [AW-1:0]                    w_raddr;
    logic [PW-1:0]                    w_rdata;
    logic [PW-1:0]                    w_peak_cur;
    sbpm_pkg::t_height                w_height;
    logic                             w_rise;
    logic [AW+sbpm_pkg::BAND_OUT_W-1:0] w_band_ext;

    for (genvar v = 0; v < BIN_N; v++) begin : g_tab
        assign w_band_tab[v] = sbpm_pkg::BIN_W'(v / BIN_STRIDE);
        assign w_off_tab[v] = OFF_W'(v % BIN_STRIDE);
    end

    assign w_band = w_band_tab[i_bin_ch.bin_index];
    assign w_off = w_off_tab[i_bin_ch.bin_index];
    assign w_offx = {{sbpm_pkg::SKIP_W{1'b0}}, w_off};
    assign w_bin_ok = (w_band < sbpm_pkg::BIN_W'(NUM_BANDS)) && (w_offx < OFX_W'(USED_BINS));
    assign w_skip = (w_band == '0) && (w_offx < {{OFF_W{1'b0}}, r_skip});
    assign w_close = (w_offx == OFX_W'(USED_BINS - 1));
    assign w_sum_base = (w_off == '0) ? '0 : r_band_sum;
    assign w_sum_add = w_skip ? '0 : {2'b00, i_bin_ch.magnitude};
    assign w_tick_inc = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;

    assign i_bin_ch.ready = (r_state == ST_IDLE);
    assign w_accept = i_bin_ch.valid && i_bin_ch.ready;
    assign w_out_free = !r_out_vld || o_res_ch.ready;

    // peak memory read address, held while a result waits
    always_comb begin
        case (r_state)
            ST_IDLE: w_raddr = w_band[AW-1:0];
            ST_GRADE: w_raddr = r_band;
            ST_DEC_RD: w_raddr = r_band;
            ST_DEC_WR: w_raddr = r_band;
            default: w_raddr = r_band;
        endcase
    end

    sbpm_ram #(
        .WIDTH(PW),
        .DEPTH(NUM_BANDS)
    ) u_peak_ram (
        .i_clk(i_clk),
        .i_we(w_we),
        .i_waddr(r_band),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    sbpm_grade #(
        .BAR_ROWS(BAR_ROWS)
    ) u_grade (
        .i_sum(r_band_sum),
        .o_height(w_height)
    );

    assign w_peak_cur = r_rd_vld ? w_rdata : '0;
    assign w_rise = (w_height > $signed({1'b0, w_peak_cur}));

    always_comb begin
        n_state = r_state;
        n_band_sum = r_band_sum;
        n_ticks = r_ticks;
        n_band = r_band;
        w_load = 1'b0;
        w_we = 1'b0;
        w_wdata = w_peak_cur;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_bin_ch.command == sbpm_pkg::CMD_TICK) begin
                        if (w_tick_inc > r_decay_period) begin
                            n_ticks = '0;
                            n_band = '0;
                            n_state = ST_DEC_RD;
                        end else begin
                            n_ticks = w_tick_inc;
                        end
                    end else if (w_bin_ok) begin
                        n_band_sum = w_sum_base + w_sum_add;
                        if (w_close) begin
                            n_band = w_band[AW-1:0];
                            n_state = ST_GRADE;
                        end
                    end
                end
            end
            ST_GRADE: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    w_we = 1'b1;
                    w_wdata = w_rise ? w_height[PW-1:0] : w_peak_cur;
                    n_band_sum = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_DEC_RD: begin
                n_state = ST_DEC_WR;
            end
            ST_DEC_WR: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    w_we = 1'b1;
                    w_wdata = (w_peak_cur != '0) ? w_peak_cur - 1'b1 : w_peak_cur;
                    if (r_band == AW'(NUM_BANDS - 1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_band = r_band + 1'b1;
                        n_state = ST_DEC_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_band_sum <= '0;
            r_ticks <= '0;
            r_band <= '0;
            r_vld <= '0;
            r_rd_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_band_sum <= n_band_sum;
            r_ticks <= n_ticks;
            r_band <= n_band;
            r_rd_vld <= r_vld[w_raddr];
            if (w_we) begin
                r_vld[r_band] <= 1'b1;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_band <= r_band;
            r_out_peak <= w_wdata;
            r_out_last <= (r_state == ST_GRADE) || (r_band == AW'(NUM_BANDS - 1));
            if (r_state == ST_GRADE) begin
                r_out_kind <= sbpm_pkg::KIND_BAR;
                r_out_height <= w_height;
            end else begin
                r_out_kind <= sbpm_pkg::KIND_DECAY;
                r_out_height <= '0;
            end
        end
    end

    // register writes
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay_period <= sbpm_pkg::DECAY_PERIOD_RST;
            r_skip <= sbpm_pkg::LOW_SKIP_RST;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                sbpm_pkg::CFG_DECAY_PERIOD: begin
                    r_decay_period <= i_cfg_ch.data[sbpm_pkg::TICK_W-1:0];
                end
                sbpm_pkg::CFG_LOW_BINS_SKIPPED: begin
                    r_skip <= i_cfg_ch.data[sbpm_pkg::SKIP_W-1:0];
                end
                default: begin
                    r_skip <= r_skip;
                end
            endcase
        end
    end

    assign w_band_ext = {{sbpm_pkg::BAND_OUT_W{1'b0}}, r_out_band};

    assign o_res_ch.valid = r_out_vld;
    assign o_res_ch.kind = r_out_kind;
    assign o_res_ch.band = w_band_ext[sbpm_pkg::BAND_OUT_W-1:0];
    assign o_res_ch.bar_height = r_out_height;
    assign o_res_ch.peak = r_out_peak;
    assign o_res_ch.last = r_out_last;

endmodule

// ----- tb/tb_spectrum_bar_peak_meter_unit.sv -----
// tb_spectrum_bar_peak_meter_unit: self-checking bench for the bar/peak meter
// drives bin and tick beats plus register writes, predicts every report, checks in order
// depends on sbpm_pkg, sbpm_if and the spectrum_bar_peak_meter_unit rtl
`timescale 1ns / 1ps

module tb_spectrum_bar_peak_meter_unit;

    localparam int BIN_W = sbpm_pkg::BIN_W;
    localparam int MAG_W = sbpm_pkg::MAG_W;
    localparam int SUM_W = sbpm_pkg::SUM_W;
    localparam int BAND_OUT_W = sbpm_pkg::BAND_OUT_W;
    localparam int HEIGHT_W = sbpm_pkg::HEIGHT_W;
    localparam int PEAK_W = sbpm_pkg::PEAK_W;
    localparam int TICK_W = sbpm_pkg::TICK_W;
    localparam int SKIP_W = sbpm_pkg::SKIP_W;
    localparam int CFG_IDX_W = sbpm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sbpm_pkg::CFG_DATA_W;
    localparam int THR_CNT = sbpm_pkg::THR_CNT;

    localparam int NUM_BANDS = sbpm_pkg::DEF_NUM_BANDS;
    localparam int BIN_STRIDE = sbpm_pkg::DEF_BIN_STRIDE;
    localparam int USED_BINS = sbpm_pkg::DEF_USED_BINS;
    localparam int BAR_ROWS = sbpm_pkg::DEF_BAR_ROWS;
    localparam int ROWS_USED = (BAR_ROWS < THR_CNT) ? BAR_ROWS : THR_CNT;
    localparam logic [63:0] SUM_MAX = (64'd1 << SUM_W) - 64'd1;
    localparam int SETTLE_CYCLES = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RAND_BEATS = 19;

    logic i_clk;
    logic i_rst_n;

    sbpm_in_if bin_ch();
    sbpm_cfg_if cfg_ch();
    sbpm_out_if res_ch();

    spectrum_bar_peak_meter_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_bin_ch (bin_ch),
        .i_cfg_ch (cfg_ch),
        .o_res_ch (res_ch)
    );

    typedef struct packed {
        logic                  kind;
        logic [BAND_OUT_W-1:0] band;
        sbpm_pkg::t_height     height;
        logic [PEAK_W-1:0]     peak;
        logic                  last;
    } t_report;

    class t_bar_peak_predictor;
        logic [TICK_W-1:0] decay_period;
        logic [SKIP_W-1:0] skip_bins;
        logic [SUM_W-1:0]  band_sum;
        logic [PEAK_W-1:0] peak_hold [NUM_BANDS];
        logic [TICK_W-1:0] tick_count;
        t_report           pending_reports [$];
        int                bar_reports;
        int                decay_reports;
        int                mismatches;

        function new();
            decay_period = sbpm_pkg::DECAY_PERIOD_RST;
            skip_bins = sbpm_pkg::LOW_SKIP_RST;
            band_sum = '0;
            tick_count = '0;
            foreach (peak_hold[i]) peak_hold[i] = '0;
            bar_reports = 0;
            decay_reports = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == sbpm_pkg::CFG_DECAY_PERIOD) begin
                decay_period = data;
            end else if (idx == sbpm_pkg::CFG_LOW_BINS_SKIPPED) begin
                skip_bins = data[SKIP_W-1:0];
            end
        endfunction

        function void take_beat(logic cmd, logic [BIN_W-1:0] bin, logic [MAG_W-1:0] mag);
            int band_no;
            int offset;
            int h;
            t_report r;
            if (cmd == sbpm_pkg::CMD_TICK) begin
                if (tick_count != '1) tick_count++;
                if (tick_count <= decay_period) return;
                tick_count = '0;
                for (int i = 0; i < NUM_BANDS; i++) begin
                    if (peak_hold[i] != '0) peak_hold[i]--;
                    r.kind = sbpm_pkg::KIND_DECAY;
                    r.band = BAND_OUT_W'(i);
                    r.height = '0;
                    r.peak = peak_hold[i];
                    r.last = (i == NUM_BANDS - 1);
                    pending_reports.push_back(r);
                end
                return;
            end
            band_no = int'(bin) / BIN_STRIDE;
            offset = int'(bin) % BIN_STRIDE;
            if (band_no >= NUM_BANDS || offset >= USED_BINS) return;
            if (offset == 0) band_sum = '0;
            if (!(band_no == 0 && offset < int'(skip_bins))) band_sum += mag;
            if (offset != USED_BINS - 1) return;
            h = -1;
            for (int k = 0; k < ROWS_USED; k++) begin
                if (band_sum >= sbpm_pkg::LEVEL_THR[k]) h = k;
            end
            band_sum = '0;
            if (h > int'(peak_hold[band_no])) peak_hold[band_no] = PEAK_W'(h);
            r.kind = sbpm_pkg::KIND_BAR;
            r.band = BAND_OUT_W'(band_no);
            r.height = HEIGHT_W'(h);
            r.peak = peak_hold[band_no];
            r.last = 1'b1;
            pending_reports.push_back(r);
        endfunction

        function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void match_report(logic kind, logic [BAND_OUT_W-1:0] band,
                                   sbpm_pkg::t_height height,
                                   logic [PEAK_W-1:0] peak, logic last);
            t_report want;
            if (pending_reports.size() == 0) begin
                $error("report with nothing pending: kind %0d band %0d", kind, band);
                mismatches++;
                return;
            end
            want = pending_reports.pop_front();
            if (want.kind == sbpm_pkg::KIND_BAR) bar_reports++;
            else decay_reports++;
            check_field("kind", want.kind, kind);
            check_field("band", want.band, band);
            check_field("bar_height", want.height, height);
            check_field("peak", want.peak, peak);
            check_field("last", want.last, last);
        endfunction
    endclass

    t_bar_peak_predictor meter = new();
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int beats_sent = 0;
    int settings_used = 1;
    int quiet_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            meter.match_report(res_ch.kind, res_ch.band, res_ch.bar_height, res_ch.peak,
                               res_ch.last);
    end

    always @(posedge i_clk) begin
        if ((bin_ch.valid && bin_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [MAG_W-1:0] random_mag();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 45_000_000);
            2: return MAG_W'(sbpm_pkg::LEVEL_THR[$urandom_range(0, THR_CNT - 1)] / 4) +
                      MAG_W'($urandom_range(0, 3));
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_beat(input logic cmd, input logic [BIN_W-1:0] bin,
                             input logic [MAG_W-1:0] mag);
        // keep the running sum inside its 34 bits
        if (cmd == sbpm_pkg::CMD_BIN && bin % BIN_STRIDE != 0 &&
            64'(meter.band_sum) + 64'(mag) > SUM_MAX)
            mag = MAG_W'(SUM_MAX - 64'(meter.band_sum));
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            bin_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        bin_ch.valid <= 1'b1;
        bin_ch.command <= cmd;
        bin_ch.bin_index <= bin;
        bin_ch.magnitude <= mag;
        @(posedge i_clk);
        while (!bin_ch.ready) @(posedge i_clk);
        meter.take_beat(cmd, bin, mag);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_band(input int band_no, input logic [MAG_W-1:0] mags [USED_BINS]);
        for (int o = 0; o < USED_BINS; o++)
            send_beat(sbpm_pkg::CMD_BIN, BIN_W'(band_no * BIN_STRIDE + o), mags[o]);
    endtask

    task automatic settle();
        bin_ch.valid <= 1'b0;
        while (meter.pending_reports.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [TICK_W-1:0] period, input logic [SKIP_W-1:0] skip);
        logic [CFG_DATA_W-1:0] skip_word;
        skip_word = {(CFG_DATA_W - SKIP_W)'($urandom()), skip};
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= sbpm_pkg::CFG_DECAY_PERIOD;
        cfg_ch.data <= period;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        meter.write_reg(sbpm_pkg::CFG_DECAY_PERIOD, period);
        @(negedge i_clk);
        cfg_ch.index <= sbpm_pkg::CFG_LOW_BINS_SKIPPED;
        cfg_ch.data <= skip_word;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        meter.write_reg(sbpm_pkg::CFG_LOW_BINS_SKIPPED, skip_word);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // mostly whole bands with random content, plus ticks and stray bins
    task automatic random_traffic(input int n);
        int done_cnt;
        int pick;
        int band_no;
        logic [BIN_W-1:0] noise_bin;
        done_cnt = 0;
        while (done_cnt < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                band_no = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, NUM_BANDS - 1);
                send_band(band_no, '{random_mag(), random_mag(), random_mag(), random_mag()});
                done_cnt += USED_BINS;
            end else if (pick < 75) begin
                send_beat(sbpm_pkg::CMD_TICK, BIN_W'($urandom()), $urandom());
                done_cnt++;
            end else begin
                noise_bin = BIN_W'($urandom());
                send_beat(sbpm_pkg::CMD_BIN, noise_bin, random_mag());
                if (noise_bin % BIN_STRIDE < USED_BINS) done_cnt++;
            end
        end
    endtask

    task automatic run_phase(input logic [TICK_W-1:0] period, input logic [SKIP_W-1:0] skip,
                             input int idle_pct, input int stall_pct, input int n);
        settle();
        write_config(period, skip);
        sender_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        random_traffic(n);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        bin_ch.valid = 1'b0;
        bin_ch.command = sbpm_pkg::CMD_BIN;
        bin_ch.bin_index = '0;
        bin_ch.magnitude = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = sbpm_pkg::CFG_DECAY_PERIOD;
        cfg_ch.data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, no idling
        send_band(0, '{'1, '1, '1, '1});
        send_band(15, '{'0, '0, '0, '0});
        send_beat(sbpm_pkg::CMD_BIN, 7'd127, '1);
        send_beat(sbpm_pkg::CMD_BIN, 7'd12, 32'h0000_1234);
        send_band(3, '{MAG_W'(sbpm_pkg::LEVEL_THR[3]), '0, '0, '0});
        send_band(4, '{'0, '0, '0, MAG_W'(sbpm_pkg::LEVEL_THR[0] - 1)});
        send_beat(sbpm_pkg::CMD_BIN, 7'd40, '1);
        send_beat(sbpm_pkg::CMD_BIN, 7'd41, '1);
        send_band(5, '{'0, '0, '0, MAG_W'(sbpm_pkg::LEVEL_THR[0])});
        send_beat(sbpm_pkg::CMD_TICK, '0, '0);

        // decay on every tick, band zero skips every used bin
        settle();
        write_config(16'd0, 3'd5);
        send_beat(sbpm_pkg::CMD_TICK, '1, '1);
        send_band(0, '{'1, '1, '1, '1});
        send_band(2, '{'0, MAG_W'(sbpm_pkg::LEVEL_THR[THR_CNT - 1]), '0, '0});
        random_traffic(RAND_BEATS);

        run_phase(16'd3, 3'd0, 57, 0, RAND_BEATS);
        run_phase(16'hFFFF, 3'd7, 0, 57, RAND_BEATS);
        run_phase(16'd2, 3'd4, 32, 32, RAND_BEATS);
        run_phase(16'd1, 3'd3, 0, 0, RAND_BEATS);
        run_phase(16'd150, 3'd1, 32, 32, RAND_BEATS);
        settle();

        $display("%0d beats over %0d register settings and four idle patterns",
                 beats_sent, settings_used);
        $display("checked %0d bar reports and %0d decay reports",
                 meter.bar_reports, meter.decay_reports);
        if (meter.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/sbpm_pkg.sv
hdl/sbpm_if.sv
hdl/sbpm_ram.sv
hdl/sbpm_grade.sv
hdl/spectrum_bar_peak_meter_unit.sv
tb/tb_spectrum_bar_peak_meter_unit.sv
